### rtl/core/assert_macros.svh
// assert_macros.svh - assertion helpers for the frame checker RTL.
// Expects signals clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/cfc_pkg.sv
// cfc_pkg.sv - shared types and constants of the command frame checker.
// No dependencies; used by cfc_parser, cfc_emitter and command_frame_checker.
`timescale 1ns / 1ps
`default_nettype none

package cfc_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CNT_W = 7;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SUM    = 2'd1;
	localparam logic [1:0] ST_MARKER = 2'd2;
	localparam logic [1:0] ST_LENGTH = 2'd3;

	// register indexes
	localparam logic [1:0] REG_FIRST_PREFIX  = 2'd0;
	localparam logic [1:0] REG_SECOND_PREFIX = 2'd1;
	localparam logic [1:0] REG_END_MARKER    = 2'd2;

	// payload store write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// end-of-frame job handed to the emitter
	typedef struct packed {
		logic             vld;
		logic [1:0]       status;
		logic [CNT_W-1:0] count;
		logic [7:0]       command;
		logic [7:0]       version;
	} job_t;

endpackage

`default_nettype wire

### rtl/core/cfc_rx_if.sv
// cfc_rx_if.sv - received byte channel (valid/ready).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cfc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       restart;

	modport source (output valid, output rx_byte, output restart, input ready);
	modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

`default_nettype wire

### rtl/core/cfc_res_if.sv
// cfc_res_if.sv - result item channel (valid/ready).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cfc_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [7:0] command_code;
	logic [7:0] version_byte;
	logic [6:0] payload_count;
	logic [1:0] status;
	logic       last_of_frame;

	modport source (output valid, output payload_byte, output command_code,
		output version_byte, output payload_count, output status,
		output last_of_frame, input ready);
	modport sink (input valid, input payload_byte, input command_code,
		input version_byte, input payload_count, input status,
		input last_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/core/cfc_parser.sv
// cfc_parser.sv - frame parse state machine and configuration registers.
// Depends on cfc_pkg; writes the payload store and hands jobs to cfc_emitter.
`timescale 1ns / 1ps
`default_nettype none

module cfc_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_idx,
	input  wire logic [7:0]        cfg_data,
	input  wire logic              take,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              restart,
	output cfc_pkg::wr_t           wr,
	output cfc_pkg::job_t          job
);
	import cfc_pkg::*;

	localparam logic [3:0] PH_HUNT0   = 4'd0;
	localparam logic [3:0] PH_HUNT1   = 4'd1;
	localparam logic [3:0] PH_VERSION = 4'd2;
	localparam logic [3:0] PH_LENLO   = 4'd3;
	localparam logic [3:0] PH_LENHI   = 4'd4;
	localparam logic [3:0] PH_COMMAND = 4'd5;
	localparam logic [3:0] PH_PAYLOAD = 4'd6;
	localparam logic [3:0] PH_CHECK   = 4'd7;
	localparam logic [3:0] PH_END     = 4'd8;

	logic [7:0]       first_q, second_q, end_q;
	logic [3:0]       phase_q, phase_d;
	logic [7:0]       sum_q, sum_d;
	logic [15:0]      len_q, len_d;
	logic [CNT_W-1:0] seen_q, seen_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [7:0]       ver_q, ver_d;
	logic [1:0]       stat_q, stat_d;
	logic [3:0]       hunt;
	logic [15:0]      len_dec, len_adj;
	logic [7:0]       sum_add;
	logic [1:0]       st_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
			end_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FIRST_PREFIX:  first_q  <= cfg_data;
				REG_SECOND_PREFIX: second_q <= cfg_data;
				REG_END_MARKER:    end_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		hunt    = (rx_byte == first_q) ? PH_HUNT1 : PH_HUNT0;
		len_dec = len_q - {15'd0, len_q != 16'd0};
		len_adj = len_q - 16'd2;
		sum_add = sum_q + rx_byte;
		st_end  = (stat_q == ST_OK && rx_byte != end_q) ? ST_MARKER : stat_q;
		phase_d = phase_q;
		sum_d   = sum_q;
		len_d   = len_q;
		seen_d  = seen_q;
		cmd_d   = cmd_q;
		ver_d   = ver_q;
		stat_d  = stat_q;
		wr      = '0;
		job     = '0;
		if (take) begin
			if (restart) begin
				phase_d = hunt;
			end else begin
				unique case (phase_q)
					PH_HUNT0: phase_d = hunt;
					PH_HUNT1: phase_d = (rx_byte == second_q) ? PH_VERSION : hunt;
					PH_VERSION: begin
						ver_d   = rx_byte;
						sum_d   = rx_byte;
						stat_d  = ST_OK;
						seen_d  = '0;
						phase_d = PH_LENLO;
					end
					PH_LENLO: begin
						len_d   = {8'd0, rx_byte};
						sum_d   = sum_add;
						phase_d = PH_LENHI;
					end
					PH_LENHI: begin
						len_d   = {rx_byte, len_q[7:0]};
						sum_d   = sum_add;
						phase_d = PH_COMMAND;
					end
					PH_COMMAND: begin
						cmd_d  = rx_byte;
						sum_d  = sum_add;
						seen_d = '0;
						if (len_q < 16'd2) begin
							stat_d  = ST_LENGTH;
							len_d   = '0;
							phase_d = PH_CHECK;
						end else begin
							len_d   = len_adj;
							if (len_adj > 16'(MAX_PAYLOAD))
								stat_d = ST_LENGTH;
							phase_d = (len_adj == 16'd0) ? PH_CHECK : PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						sum_d = sum_add;
						if (stat_q == ST_OK && seen_q < CNT_W'(MAX_PAYLOAD)) begin
							wr.en   = 1'b1;
							wr.addr = seen_q[ADDR_W-1:0];
							wr.data = rx_byte;
							seen_d  = seen_q + 1'b1;
						end
						len_d = len_dec;
						if (len_dec == 16'd0)
							phase_d = PH_CHECK;
					end
					PH_CHECK: begin
						if (rx_byte != sum_q && stat_q == ST_OK)
							stat_d = ST_SUM;
						phase_d = PH_END;
					end
					PH_END: begin
						stat_d      = st_end;
						job.vld     = 1'b1;
						job.status  = st_end;
						job.count   = (st_end == ST_LENGTH) ? '0 : seen_q;
						job.command = cmd_q;
						job.version = ver_q;
						phase_d     = PH_HUNT0;
					end
					default: phase_d = PH_HUNT0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT0;
			sum_q   <= '0;
			len_q   <= '0;
			seen_q  <= '0;
			cmd_q   <= '0;
			ver_q   <= '0;
			stat_q  <= ST_OK;
		end else begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
			cmd_q   <= cmd_d;
			ver_q   <= ver_d;
			stat_q  <= stat_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/cfc_emitter.sv
// cfc_emitter.sv - payload store and result drain with output register.
// Depends on cfc_pkg, cfc_res_if and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cfc_emitter (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfc_pkg::wr_t  wr,
	input  wire cfc_pkg::job_t job,
	output logic               idle,
	cfc_res_if.source          res
);
	import cfc_pkg::*;

	localparam logic [1:0] E_IDLE   = 2'd0;
	localparam logic [1:0] E_SINGLE = 2'd1;
	localparam logic [1:0] E_READ   = 2'd2;
	localparam logic [1:0] E_WAIT   = 2'd3;

	logic [7:0]       mem [MAX_PAYLOAD];
	logic [7:0]       rd_data_q;
	logic [1:0]       state_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [1:0]       j_status_q;
	logic [CNT_W-1:0] j_count_q;
	logic [7:0]       j_cmd_q, j_ver_q;
	logic             res_vld_q;
	logic [7:0]       res_byte_q;
	logic [7:0]       res_cmd_q, res_ver_q;
	logic [CNT_W-1:0] res_cnt_q;
	logic [1:0]       res_stat_q;
	logic             res_last_q;
	logic             out_free, load, single, is_last;
	logic [CNT_W-1:0] idx_inc;

	assign idle     = (state_q == E_IDLE);
	assign out_free = !res_vld_q || res.ready;
	assign load     = out_free && (state_q == E_WAIT || state_q == E_SINGLE);
	assign single   = (job.status != ST_OK) || (job.count == '0);
	assign idx_inc  = rd_idx_q + 1'b1;
	assign is_last  = (idx_inc == j_count_q);

	// storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		if (state_q == E_READ)
			rd_data_q <= mem[rd_idx_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= E_IDLE;
			rd_idx_q  <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (load)
				res_vld_q <= 1'b1;
			else if (res.ready)
				res_vld_q <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					rd_idx_q <= '0;
					if (job.vld)
						state_q <= single ? E_SINGLE : E_READ;
				end
				E_SINGLE: if (out_free) state_q <= E_IDLE;
				E_READ:   state_q <= E_WAIT;
				E_WAIT: begin
					if (out_free) begin
						rd_idx_q <= idx_inc;
						state_q  <= is_last ? E_IDLE : E_READ;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	// job fields may be replaced by the next frame while the last item waits,
	// so every output field lives in the output register
	always_ff @(posedge clk) begin
		if (job.vld && state_q == E_IDLE) begin
			j_status_q <= job.status;
			j_count_q  <= job.count;
			j_cmd_q    <= job.command;
			j_ver_q    <= job.version;
		end
		if (load) begin
			res_byte_q <= (state_q == E_WAIT) ? rd_data_q : 8'd0;
			res_cmd_q  <= j_cmd_q;
			res_ver_q  <= j_ver_q;
			res_cnt_q  <= j_count_q;
			res_stat_q <= j_status_q;
			res_last_q <= (state_q == E_WAIT) ? is_last : 1'b1;
		end
	end

	assign res.valid         = res_vld_q;
	assign res.payload_byte  = res_byte_q;
	assign res.command_code  = res_cmd_q;
	assign res.version_byte  = res_ver_q;
	assign res.payload_count = res_cnt_q;
	assign res.status        = res_stat_q;
	assign res.last_of_frame = res_last_q;

	`CFC_ASSERT_IMP(a_wr_idle, wr.en, state_q == E_IDLE, "store written during drain")
	`CFC_ASSERT_IMP(a_job_idle, job.vld, state_q == E_IDLE, "job while emitter busy")
	`CFC_ASSERT_IMP(a_idx_range, state_q == E_WAIT || state_q == E_READ, rd_idx_q < j_count_q, "read index past count")

endmodule

`default_nettype wire

### rtl/core/command_frame_checker.sv
// command_frame_checker.sv - top level: frame parser plus payload drain.
// Depends on cfc_pkg, cfc_rx_if, cfc_res_if, cfc_parser, cfc_emitter.
//
//  channel  dir  fields                                             handshake
//  rx       in   rx_byte[8], restart[1]                             valid/ready
//  res      out  payload_byte, command_code, version_byte,          valid/ready
//                payload_count[7], status[2], last_of_frame
//  cfg      in   cfg_we, cfg_idx[2], cfg_data[8]                    write only
//
// A received byte is taken whenever the drain is idle.
// A frame with n > 0 good payload bytes drains as n items, each a store read
// then an output register load, held while res stalls; other frames give one item.
// rx is held off while draining, so the store is never written and read at once.
// Reset is asynchronous; the store itself needs no clearing (only entries
// of the current frame are read).
`timescale 1ns / 1ps
`default_nettype none

module command_frame_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [7:0] cfg_data,
	cfc_rx_if.sink          rx,
	cfc_res_if.source       res
);
	import cfc_pkg::*;

	wr_t  wr;
	job_t job;
	logic em_idle;
	logic take;

	// bytes flow whenever the drain is idle, even with a result still held
	assign rx.ready = em_idle;
	assign take     = rx.valid && em_idle;

	cfc_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.take     (take),
		.rx_byte  (rx.rx_byte),
		.restart  (rx.restart),
		.wr       (wr),
		.job      (job)
	);

	cfc_emitter u_emitter (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.job    (job),
		.idle   (em_idle),
		.res    (res)
	);

endmodule

`default_nettype wire
